@@ src/cfa_pkg.sv @@
// Shared types and codes for the contiguous frame allocator.
package cfa_pkg;

  typedef enum logic [1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_ALLOC   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_MARK    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NO_RUN  = 3'd1,
    STAT_NO_HEAD = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_ZERO    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FS_FREE  = 2'd0,
    FS_HEAD  = 2'd1,
    FS_INACC = 2'd2,
    FS_ALLOC = 2'd3
  } frame_st_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ICLR, S_IRES, S_ARD, S_ACHK, S_AWR,
    S_RRD, S_RCHK, S_MRD, S_MCHK, S_DONE
  } state_t;

  localparam logic [1:0] REG_BASE_FRAME    = 2'd0;
  localparam logic [1:0] REG_POOL_FRAMES   = 2'd1;
  localparam logic [1:0] REG_RESERVE_FIRST = 2'd2;

  localparam int unsigned CNT_BITS = 11;
  localparam int unsigned POOL_RESET = 1024;

endpackage

@@ src/cfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cfa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/contiguous_frame_allocator_top.sv @@
// Top level of the contiguous frame allocator.
//
// The block keeps a two-bit status for every frame of a pool in a status RAM.
// Requests arrive on the s_ channel (func, frame_number, frame_count) and one
// result per request leaves on the m_ channel (result_frame, status,
// free_frames). Registers base_frame, pool_frames and reserve_first are
// written on the cfg_ channel, which is always ready.
// A single sequencer walks the status RAM, with a read state and a check state
// per frame for the scan, release and mark loops, and one frame per cycle when
// writing an allocated run or clearing the map.
// The block takes one request at a time and is not ready while it works.
// After reset the status RAM is cleared, one entry per cycle, and no request is
// accepted until that is done.
// A result is held in the output register until the receiver takes it; the
// next request is accepted only after that.
module contiguous_frame_allocator_top #(
  parameter int unsigned MAX_FRAMES = 1024,
  parameter int unsigned FRAME_NUMBER_BITS = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // func[1:0], frame_number, frame_count, zero pad
  input  logic [((13 + FRAME_NUMBER_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // result_frame, status[2:0], free_frames[10:0], zero pad
  output logic [((14 + FRAME_NUMBER_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [(FRAME_NUMBER_BITS > 11 ? FRAME_NUMBER_BITS : 11) - 1:0] cfg_data
);

  import cfa_pkg::*;

  localparam int unsigned FNB = FRAME_NUMBER_BITS;
  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned CW = NW > CNT_BITS ? NW : CNT_BITS;
  localparam int unsigned WW = (FNB > CW ? FNB : CW) + 2;
  localparam int unsigned OUT_W = ((14 + FNB + 7) / 8) * 8;
  localparam int unsigned RESET_FREE = POOL_RESET > MAX_FRAMES ? MAX_FRAMES : POOL_RESET;

  state_t state, state_next;

  logic [FNB-1:0]      base_frame;
  logic [CNT_BITS-1:0] pool_frames;
  logic                reserve_first;

  logic [CW-1:0]  idx, idx_next;
  logic [CW-1:0]  run, run_next;
  logic [CW-1:0]  start, start_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  last, last_next;
  logic           first, first_next;
  logic [CW-1:0]  free_count, free_count_next;
  status_t        stat, stat_next;
  logic [FNB-1:0] rframe, rframe_next;

  logic [CW-1:0]  n;
  logic [1:0]     in_func;
  logic [FNB-1:0] in_fn;
  logic [CW-1:0]  in_cnt;
  logic [FNB-1:0] off;
  logic           below;

  logic           ram_we;
  logic [1:0]     ram_wdata;
  logic [1:0]     ram_rdata;

  assign cfg_ready = 1'b1;

  assign n = (CW'(pool_frames) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(pool_frames);
  assign in_func = s_tdata[1:0];
  assign in_fn = s_tdata[FNB+1:2];
  assign in_cnt = CW'(s_tdata[FNB+12:FNB+2]);
  assign off = in_fn - base_frame;
  assign below = in_fn < base_frame;

  assign m_tdata = OUT_W'({free_count[CNT_BITS-1:0], stat, rframe});

  cfa_ram #(.WIDTH(2), .DEPTH(MAX_FRAMES)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      base_frame <= '0;
      pool_frames <= CNT_BITS'(POOL_RESET);
      reserve_first <= 1'b0;
      idx <= '0;
      free_count <= CW'(RESET_FREE);
    end else begin
      state <= state_next;
      idx <= idx_next;
      free_count <= free_count_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_BASE_FRAME: base_frame <= cfg_data[FNB-1:0];
          REG_POOL_FRAMES: pool_frames <= cfg_data[CNT_BITS-1:0];
          REG_RESERVE_FIRST: reserve_first <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    run <= run_next;
    start <= start_next;
    cnt <= cnt_next;
    last <= last_next;
    first <= first_next;
    stat <= stat_next;
    rframe <= rframe_next;
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    run_next = run;
    start_next = start;
    cnt_next = cnt;
    last_next = last;
    first_next = first;
    free_count_next = free_count;
    stat_next = stat;
    rframe_next = rframe;
    case (state)
      S_CLR: begin
        idx_next = idx + 1'b1;
        if (idx == CW'(MAX_FRAMES - 1)) begin
          idx_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          stat_next = STAT_OK;
          rframe_next = '0;
          cnt_next = in_cnt;
          case (func_t'(in_func))
            FUNC_INIT: begin
              idx_next = '0;
              state_next = S_ICLR;
            end
            FUNC_ALLOC: begin
              idx_next = '0;
              run_next = '0;
              if (in_cnt == '0) begin
                stat_next = STAT_ZERO;
                state_next = S_DONE;
              end else begin
                state_next = S_ARD;
              end
            end
            FUNC_RELEASE: begin
              idx_next = CW'(off);
              first_next = 1'b1;
              if (below || WW'(off) >= WW'(n)) begin
                stat_next = STAT_RANGE;
                state_next = S_DONE;
              end else begin
                state_next = S_RRD;
              end
            end
            default: begin
              idx_next = CW'(off);
              last_next = CW'(off) + in_cnt - 1'b1;
              if (in_cnt == '0) begin
                stat_next = STAT_ZERO;
                state_next = S_DONE;
              end else if (below || WW'(off) + WW'(in_cnt) > WW'(n)) begin
                stat_next = STAT_RANGE;
                state_next = S_DONE;
              end else begin
                state_next = S_MRD;
              end
            end
          endcase
        end
      end
      S_ICLR: begin
        idx_next = idx + 1'b1;
        if (idx == CW'(MAX_FRAMES - 1)) begin
          idx_next = '0;
          free_count_next = n;
          if (reserve_first && n != '0) begin
            state_next = S_IRES;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_IRES: begin
        free_count_next = free_count - 1'b1;
        state_next = S_DONE;
      end
      S_ARD: begin
        if (idx >= n) begin
          stat_next = STAT_NO_RUN;
          state_next = S_DONE;
        end else begin
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        idx_next = idx + 1'b1;
        state_next = S_ARD;
        if (ram_rdata == FS_FREE) begin
          run_next = run + 1'b1;
          if (run == '0) begin
            start_next = idx;
          end
          if (run + 1'b1 == cnt) begin
            idx_next = (run == '0) ? idx : start;
            start_next = (run == '0) ? idx : start;
            state_next = S_AWR;
          end
        end else begin
          run_next = '0;
        end
      end
      S_AWR: begin
        idx_next = idx + 1'b1;
        if (idx == start + cnt - 1'b1) begin
          free_count_next = (free_count >= cnt) ? free_count - cnt : '0;
          rframe_next = base_frame + FNB'(start);
          state_next = S_DONE;
        end
      end
      S_RRD: begin
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (first ? (ram_rdata == FS_HEAD) : (ram_rdata == FS_ALLOC)) begin
          free_count_next = free_count + 1'b1;
          idx_next = idx + 1'b1;
          first_next = 1'b0;
          state_next = (idx + 1'b1 >= n) ? S_DONE : S_RRD;
        end else begin
          if (first) begin
            stat_next = STAT_NO_HEAD;
          end
          state_next = S_DONE;
        end
      end
      S_MRD: begin
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (ram_rdata == FS_FREE && free_count != '0) begin
          free_count_next = free_count - 1'b1;
        end
        idx_next = idx + 1'b1;
        state_next = (idx == last) ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    ram_we = 1'b0;
    ram_wdata = FS_FREE;
    case (state)
      S_CLR, S_ICLR: ram_we = 1'b1;
      S_IDLE: s_tready = 1'b1;
      S_IRES: begin
        ram_we = 1'b1;
        ram_wdata = FS_HEAD;
      end
      S_AWR: begin
        ram_we = 1'b1;
        ram_wdata = (idx == start) ? FS_HEAD : FS_ALLOC;
      end
      S_RCHK: begin
        ram_we = first ? (ram_rdata == FS_HEAD) : (ram_rdata == FS_ALLOC);
      end
      S_MCHK: begin
        ram_we = 1'b1;
        ram_wdata = FS_INACC;
      end
      S_DONE: m_tvalid = 1'b1;
      default: ;
    endcase
  end

endmodule
